>>> sv/tbo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared widths, word types and index tables of the triangle / box test.
// ----------------------------------------------------------------------------
package tbo_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int HALF_WIDTH  = 19;
    localparam int INDEX_WIDTH = 2;

    localparam logic [INDEX_WIDTH-1:0] REG_HALF_X = 2'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_HALF_Y = 2'd1;
    localparam logic [INDEX_WIDTH-1:0] REG_HALF_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] first_z;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] second_z;
        logic signed [COORD_WIDTH-1:0] third_x;
        logic signed [COORD_WIDTH-1:0] third_y;
        logic signed [COORD_WIDTH-1:0] third_z;
    } tbo_item_t;

    typedef struct packed {
        logic overlaps;
    } tbo_result_t;

    // Vertex pair whose projections bound the triangle on each edge axis.
    localparam int PAIR_A [3][3] = '{'{0, 0, 1}, '{0, 0, 0}, '{0, 0, 1}};
    localparam int PAIR_B [3][3] = '{'{2, 2, 2}, '{2, 2, 1}, '{1, 1, 2}};

    function automatic int next_axis(input int k);
        return (k + 1) % 3;
    endfunction

    function automatic int prev_axis(input int k);
        return (k + 2) % 3;
    endfunction

endpackage
`default_nettype wire

>>> sv/tbo_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_item_if
// Input channel carrying one triangle and one box center per word.
// ----------------------------------------------------------------------------
interface tbo_item_if;
    logic               valid;
    logic               ready;
    tbo_pkg::tbo_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/tbo_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_result_if
// Output channel carrying one overlap flag per word.
// ----------------------------------------------------------------------------
interface tbo_result_if;
    logic                 valid;
    logic                 ready;
    tbo_pkg::tbo_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/tbo_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_cfg_if
// Register write channel: register index and write data per word.
// ----------------------------------------------------------------------------
interface tbo_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tbo_pkg::INDEX_WIDTH-1:0]      index;
    logic [tbo_pkg::HALF_WIDTH-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/triangle_box_overlap_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Separating-axis overlap test of a triangle against an axis-aligned box.
// ----------------------------------------------------------------------------
// Each word on the item channel carries a box center and three triangle
// vertices; each word on the result channel carries one overlap flag, in
// the same order. The box half extents are written on the cfg channel,
// which is always ready, and must only change while the pipeline is empty.
// The datapath is a six-register pipeline: translation and edges, the
// products, the differences and the normal, the edge axis checks with the
// split plane products, the plane sums, and the output register. Each item
// passes through the six registers in order, and one item is taken every
// cycle while the result channel keeps up.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and the item channel drops ready; nothing is lost or repeated.
// Reset clears all valid bits and sets the half extents to zero.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test (
    input  wire           clk,
    input  wire           rst_n,
    tbo_item_if.sink      item,
    tbo_result_if.source  result,
    tbo_cfg_if.sink       cfg
);
    import tbo_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int HW   = HALF_WIDTH;
    localparam int VW   = CW + 1;
    localparam int EW   = CW + 2;
    localparam int PW   = EW + VW;
    localparam int AW   = PW + 1;
    localparam int RPW  = EW + HW;
    localparam int RW   = RPW + 1;
    localparam int TW   = ((AW > RW) ? AW : RW) + 2;
    localparam int FW   = ((VW > HW + 1) ? VW : HW + 1) + 1;
    localparam int NPW  = 2 * EW;
    localparam int NW   = NPW + 1;
    localparam int PAW  = FW + 1;
    localparam int NLO  = (NW + 1) / 2;
    localparam int NHI  = NW - NLO;
    localparam int LPW  = NLO + 1 + PAW;
    localparam int HPW  = NHI + PAW;
    localparam int DW   = NW + PAW + 2;

    logic [HW-1:0] half_reg [3];

    logic adv;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, out_vld_reg;

    logic signed [VW-1:0]  v_reg [3][3];
    logic signed [EW-1:0]  e_reg [3][3];

    logic signed [PW-1:0]  pja_reg [3][3], pia_reg [3][3], pjb_reg [3][3], pib_reg [3][3];
    logic [RPW-1:0]        rj_reg [3][3], ri_reg [3][3];
    logic signed [NPW-1:0] n1_reg [3], n2_reg [3];
    logic signed [VW-1:0]  v0_s2_reg [3];
    logic                  face_ok_s2_reg;

    logic signed [AW-1:0]  pa_reg [3][3], pb_reg [3][3];
    logic [RW-1:0]         rad_reg [3][3];
    logic signed [NW-1:0]  n_reg [3];
    logic signed [VW-1:0]  v0_s3_reg [3];
    logic                  face_ok_s3_reg;

    logic signed [LPW-1:0] lmin_reg [3], lmax_reg [3];
    logic signed [HPW-1:0] hmin_reg [3], hmax_reg [3];
    logic                  axes_ok_reg;

    logic signed [DW-1:0]  dmin_reg, dmax_reg;
    logic                  axes_ok_s5_reg;

    logic                  overlaps_reg;

    logic signed [VW-1:0]  v_next [3][3];
    logic signed [EW-1:0]  e_next [3][3];
    logic signed [CW-1:0]  pt [3][3];
    logic signed [CW-1:0]  ctr [3];
    logic signed [PW-1:0]  pja_next [3][3], pia_next [3][3], pjb_next [3][3], pib_next [3][3];
    logic [RPW-1:0]        rj_next [3][3], ri_next [3][3];
    logic signed [NPW-1:0] n1_next [3], n2_next [3];
    logic [EW-1:0]         ae [3][3];
    logic                  face_ok_next;
    logic signed [VW-1:0]  vmin, vmax;
    logic signed [FW-1:0]  hs;
    logic signed [FW-1:0]  hq;
    logic signed [AW-1:0]  pa_next [3][3], pb_next [3][3];
    logic [RW-1:0]         rad_next [3][3];
    logic signed [NW-1:0]  n_next [3];
    logic signed [TW-1:0]  plo, phi, rs;
    logic                  edge_ok;
    logic signed [PAW-1:0] am, ax;
    logic signed [NLO:0]   nlo;
    logic signed [NHI-1:0] nhi;
    logic signed [LPW-1:0] lmin_next [3], lmax_next [3];
    logic signed [HPW-1:0] hmin_next [3], hmax_next [3];
    logic signed [DW-1:0]  dmin_next, dmax_next;
    logic                  overlaps_next;

    assign adv          = !out_vld_reg || result.ready;
    assign item.ready   = adv;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_vld_reg;
    assign result.data.overlaps = overlaps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg[0] <= '0;
            half_reg[1] <= '0;
            half_reg[2] <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HALF_X: half_reg[0] <= cfg.data;
                REG_HALF_Y: half_reg[1] <= cfg.data;
                REG_HALF_Z: half_reg[2] <= cfg.data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= item.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            out_vld_reg <= s5_vld_reg;
        end
    end

    // Stage one: translate to the box center and form the edges.
    always_comb
    begin
        ctr[0] = item.data.center_x;
        ctr[1] = item.data.center_y;
        ctr[2] = item.data.center_z;
        pt[0][0] = item.data.first_x;
        pt[0][1] = item.data.first_y;
        pt[0][2] = item.data.first_z;
        pt[1][0] = item.data.second_x;
        pt[1][1] = item.data.second_y;
        pt[1][2] = item.data.second_z;
        pt[2][0] = item.data.third_x;
        pt[2][1] = item.data.third_y;
        pt[2][2] = item.data.third_z;
        for (int t = 0; t < 3; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v_next[t][k] = VW'(pt[t][k]) - VW'(ctr[k]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            e_next[0][k] = EW'(v_next[1][k]) - EW'(v_next[0][k]);
            e_next[1][k] = EW'(v_next[2][k]) - EW'(v_next[1][k]);
            e_next[2][k] = EW'(v_next[0][k]) - EW'(v_next[2][k]);
        end
    end

    // Stage two: all products at full width, and the face axes.
    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ae[t][k] = e_reg[t][k][EW-1] ? EW'(-e_reg[t][k]) : EW'(e_reg[t][k]);
            end
        end
        for (int t = 0; t < 3; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pja_next[t][k] = PW'(e_reg[t][prev_axis(k)])
                               * PW'(v_reg[PAIR_A[t][k]][next_axis(k)]);
                pia_next[t][k] = PW'(e_reg[t][next_axis(k)])
                               * PW'(v_reg[PAIR_A[t][k]][prev_axis(k)]);
                pjb_next[t][k] = PW'(e_reg[t][prev_axis(k)])
                               * PW'(v_reg[PAIR_B[t][k]][next_axis(k)]);
                pib_next[t][k] = PW'(e_reg[t][next_axis(k)])
                               * PW'(v_reg[PAIR_B[t][k]][prev_axis(k)]);
                rj_next[t][k]  = RPW'(ae[t][prev_axis(k)]) * RPW'(half_reg[next_axis(k)]);
                ri_next[t][k]  = RPW'(ae[t][next_axis(k)]) * RPW'(half_reg[prev_axis(k)]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            n1_next[k] = NPW'(e_reg[0][next_axis(k)]) * NPW'(e_reg[1][prev_axis(k)]);
            n2_next[k] = NPW'(e_reg[0][prev_axis(k)]) * NPW'(e_reg[1][next_axis(k)]);
        end
        face_ok_next = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            vmin = v_reg[0][k];
            vmax = v_reg[0][k];
            for (int t = 1; t < 3; t++)
            begin
                if (v_reg[t][k] < vmin)
                begin
                    vmin = v_reg[t][k];
                end
                if (v_reg[t][k] > vmax)
                begin
                    vmax = v_reg[t][k];
                end
            end
            hs = $signed({{(FW - HW){1'b0}}, half_reg[k]});
            if (FW'(vmin) > hs || FW'(vmax) < -hs)
            begin
                face_ok_next = 1'b0;
            end
        end
    end

    // Stage three: projections, radii and the triangle normal.
    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_next[t][k]  = AW'(pja_reg[t][k]) - AW'(pia_reg[t][k]);
                pb_next[t][k]  = AW'(pjb_reg[t][k]) - AW'(pib_reg[t][k]);
                rad_next[t][k] = RW'(rj_reg[t][k]) + RW'(ri_reg[t][k]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            n_next[k] = NW'(n1_reg[k]) - NW'(n2_reg[k]);
        end
    end

    // Stage four: edge axis checks and split plane products.
    always_comb
    begin
        edge_ok = 1'b1;
        for (int t = 0; t < 3; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (pa_reg[t][k] < pb_reg[t][k])
                begin
                    plo = TW'(pa_reg[t][k]);
                    phi = TW'(pb_reg[t][k]);
                end
                else
                begin
                    plo = TW'(pb_reg[t][k]);
                    phi = TW'(pa_reg[t][k]);
                end
                rs = $signed({{(TW - RW){1'b0}}, rad_reg[t][k]});
                if (rs < plo || phi < -rs)
                begin
                    edge_ok = 1'b0;
                end
            end
        end
        for (int q = 0; q < 3; q++)
        begin
            hq = $signed({{(FW - HW){1'b0}}, half_reg[q]});
            if (n_reg[q] > 0)
            begin
                am = PAW'(-hq) - PAW'(v0_s3_reg[q]);
                ax = PAW'(hq) - PAW'(v0_s3_reg[q]);
            end
            else
            begin
                am = PAW'(hq) - PAW'(v0_s3_reg[q]);
                ax = PAW'(-hq) - PAW'(v0_s3_reg[q]);
            end
            nlo = $signed({1'b0, n_reg[q][NLO-1:0]});
            nhi = n_reg[q][NW-1:NLO];
            lmin_next[q] = LPW'(nlo) * LPW'(am);
            lmax_next[q] = LPW'(nlo) * LPW'(ax);
            hmin_next[q] = HPW'(nhi) * HPW'(am);
            hmax_next[q] = HPW'(nhi) * HPW'(ax);
        end
    end

    // Stage five: plane distances of the two extreme box corners.
    always_comb
    begin
        dmin_next = '0;
        dmax_next = '0;
        for (int q = 0; q < 3; q++)
        begin
            dmin_next = dmin_next + (DW'(hmin_reg[q]) <<< NLO) + DW'(lmin_reg[q]);
            dmax_next = dmax_next + (DW'(hmax_reg[q]) <<< NLO) + DW'(lmax_reg[q]);
        end
    end

    assign overlaps_next = axes_ok_s5_reg && !(dmin_reg > 0) && !(dmax_reg < 0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg          <= v_next;
            e_reg          <= e_next;
            pja_reg        <= pja_next;
            pia_reg        <= pia_next;
            pjb_reg        <= pjb_next;
            pib_reg        <= pib_next;
            rj_reg         <= rj_next;
            ri_reg         <= ri_next;
            n1_reg         <= n1_next;
            n2_reg         <= n2_next;
            v0_s2_reg      <= v_reg[0];
            face_ok_s2_reg <= face_ok_next;
            pa_reg         <= pa_next;
            pb_reg         <= pb_next;
            rad_reg        <= rad_next;
            n_reg          <= n_next;
            v0_s3_reg      <= v0_s2_reg;
            face_ok_s3_reg <= face_ok_s2_reg;
            lmin_reg       <= lmin_next;
            lmax_reg       <= lmax_next;
            hmin_reg       <= hmin_next;
            hmax_reg       <= hmax_next;
            axes_ok_reg    <= edge_ok && face_ok_s3_reg;
            dmin_reg       <= dmin_next;
            dmax_reg       <= dmax_next;
            axes_ok_s5_reg <= axes_ok_reg;
            overlaps_reg   <= overlaps_next;
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg,
                          s5_vld_reg, out_vld_reg}))
        else $error("pipeline valid bits moved during a stall");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s3_vld_reg) |=> s4_vld_reg)
        else $error("word lost between stages three and four");

    a_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(s5_vld_reg))
        else $error("result appeared without a word in the last stage");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> item.ready)
        else $error("input stalled while the output register is empty");

endmodule
`default_nettype wire

>>> dv/tb_triangle_box_overlap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_box_overlap_test
// Self-checking bench for the triangle / box separating-axis overlap test.
// ----------------------------------------------------------------------------
// Triangles and box centers go in on the item channel and overlap flags come
// back on the result channel. A predictor recomputes each flag with exact
// wide integer arithmetic under the current half extents. Directed cases
// cover touching, separation on each kind of axis, degenerate triangles and
// the extreme coordinates; random phases under several box sizes follow,
// with random gaps on both sides and long receiver stalls.
// ----------------------------------------------------------------------------
module tb_triangle_box_overlap_test;
    import tbo_pkg::*;

    typedef logic signed [127:0] acc_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tbo_item_if   item ();
    tbo_result_if result ();
    tbo_cfg_if    cfg ();

    triangle_box_overlap_test dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always #5 clk = ~clk;

    logic [HALF_WIDTH-1:0] box_half [3];
    logic                  expected_flags [$];
    int                    mismatches = 0;
    int                    idle_cycles = 0;
    bit                    hold_off = 1'b0;
    int                    hold_cycles = 0;
    int                    rx_wait = 0;
    int                    rx_draw = 0;
    bit                    timed_out = 1'b0;
    localparam int         WATCHDOG = 20000;

    function automatic logic predict_overlap(input tbo_item_t w);
        acc_t c [3], p [3][3], v [3][3], e [3][3], h [3], n [3];
        acc_t pa, pb, rad, lo, hi, dmin, dmax, a, b;
        int i, j, va, vb;
        logic hit;
        hit = 1'b1;
        c[0] = w.center_x; c[1] = w.center_y; c[2] = w.center_z;
        p[0][0] = w.first_x;  p[0][1] = w.first_y;  p[0][2] = w.first_z;
        p[1][0] = w.second_x; p[1][1] = w.second_y; p[1][2] = w.second_z;
        p[2][0] = w.third_x;  p[2][1] = w.third_y;  p[2][2] = w.third_z;
        for (int k = 0; k < 3; k++)
        begin
            h[k] = {109'd0, box_half[k]};
            for (int t = 0; t < 3; t++)
                v[t][k] = p[t][k] - c[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            e[0][k] = v[1][k] - v[0][k];
            e[1][k] = v[2][k] - v[1][k];
            e[2][k] = v[0][k] - v[2][k];
        end
        for (int t = 0; t < 3; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                i = (k + 1) % 3;
                j = (k + 2) % 3;
                va = (t == 0 && k == 2) || (t == 2 && k == 2) ? 1 : 0;
                vb = (t == 1 && k == 2) || (t == 2 && k < 2) ? 1 : 2;
                pa = e[t][j] * v[va][i] - e[t][i] * v[va][j];
                pb = e[t][j] * v[vb][i] - e[t][i] * v[vb][j];
                rad = (e[t][j] < 0 ? -e[t][j] : e[t][j]) * h[i]
                    + (e[t][i] < 0 ? -e[t][i] : e[t][i]) * h[j];
                lo = pa < pb ? pa : pb;
                hi = pa < pb ? pb : pa;
                if (rad < lo || hi < -rad)
                    hit = 1'b0;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            lo = v[0][k];
            hi = v[0][k];
            for (int t = 1; t < 3; t++)
            begin
                if (v[t][k] < lo) lo = v[t][k];
                if (v[t][k] > hi) hi = v[t][k];
            end
            if (lo > h[k] || hi < -h[k])
                hit = 1'b0;
        end
        if (hit)
        begin
            dmin = 0;
            dmax = 0;
            for (int k = 0; k < 3; k++)
            begin
                i = (k + 1) % 3;
                j = (k + 2) % 3;
                n[k] = e[0][i] * e[1][j] - e[0][j] * e[1][i];
            end
            for (int q = 0; q < 3; q++)
            begin
                if (n[q] > 0)
                begin
                    a = -h[q] - v[0][q];
                    b = h[q] - v[0][q];
                end
                else
                begin
                    a = h[q] - v[0][q];
                    b = -h[q] - v[0][q];
                end
                dmin = dmin + n[q] * a;
                dmax = dmax + n[q] * b;
            end
            if (dmin > 0 || dmax < 0)
                hit = 1'b0;
        end
        return hit;
    endfunction

    task automatic send_word(input tbo_item_t w);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.data  <= w;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        expected_flags.push_back(predict_overlap(w));
    endtask

    task automatic write_half(input logic [INDEX_WIDTH-1:0] idx,
                              input logic [HALF_WIDTH-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        box_half[idx] = value;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_box(input logic [HALF_WIDTH-1:0] hx,
                           input logic [HALF_WIDTH-1:0] hy,
                           input logic [HALF_WIDTH-1:0] hz);
        write_half(REG_HALF_X, hx);
        write_half(REG_HALF_Y, hy);
        write_half(REG_HALF_Z, hz);
    endtask

    task automatic drain;
        item.valid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord(input int spread);
        case (spread)
            0: return $urandom_range(0, 1) ? 20'sh7ffff : 20'sh80000;
            1: return COORD_WIDTH'($urandom);
            default: return COORD_WIDTH'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    function automatic tbo_item_t make_triangle(input int spread, input int off);
        tbo_item_t w;
        w = '0;
        w.center_x = rand_coord(spread);
        w.center_y = rand_coord(spread);
        w.center_z = rand_coord(spread);
        w.first_x  = w.center_x + rand_coord(off);
        w.first_y  = w.center_y + rand_coord(off);
        w.first_z  = w.center_z + rand_coord(off);
        w.second_x = w.center_x + rand_coord(off);
        w.second_y = w.center_y + rand_coord(off);
        w.second_z = w.center_z + rand_coord(off);
        w.third_x  = w.center_x + rand_coord(off);
        w.third_y  = w.center_y + rand_coord(off);
        w.third_z  = w.center_z + rand_coord(off);
        return w;
    endfunction

    function automatic tbo_item_t tri_at(input int ax, ay, az, bx, by, bz,
                                         input int cx, cy, cz);
        tbo_item_t w;
        w = '0;
        w.first_x = COORD_WIDTH'(ax);  w.first_y = COORD_WIDTH'(ay);
        w.first_z = COORD_WIDTH'(az);
        w.second_x = COORD_WIDTH'(bx); w.second_y = COORD_WIDTH'(by);
        w.second_z = COORD_WIDTH'(bz);
        w.third_x = COORD_WIDTH'(cx);  w.third_y = COORD_WIDTH'(cy);
        w.third_z = COORD_WIDTH'(cz);
        return w;
    endfunction

    task automatic test_directed;
        tbo_item_t w;
        set_box(19'd256, 19'd256, 19'd256);
        send_word(tri_at(0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_word(tri_at(256, -512, -512, 256, 512, -512, 256, 0, 512));
        send_word(tri_at(257, -512, -512, 257, 512, -512, 257, 0, 512));
        send_word(tri_at(-257, 0, 0, -600, 10, 0, -600, 0, 10));
        send_word(tri_at(0, 0, 300, 0, 300, 0, 300, 0, 0));
        send_word(tri_at(0, 0, 1000, 0, 1000, 0, 1000, 0, 0));
        send_word(tri_at(0, 0, 768, 0, 768, 0, 768, 0, 0));
        send_word(tri_at(0, 0, 769, 0, 769, 0, 769, 0, 0));
        send_word(tri_at(-400, 0, 0, 400, 0, 0, 0, 0, 0));
        send_word(tri_at(10, 10, 10, 10, 10, 10, 10, 10, 10));
        send_word(tri_at(300, 300, 0, 300, 300, 0, 300, 300, 0));
        send_word(tri_at(-1000, 1000, 0, 1000, -1000, 0, 1000, 1000, 5));
        send_word(tri_at(600, 0, -600, 0, 600, -600, 600, 600, 600));
        w = '0;
        w.center_x = 20'sh80000; w.center_y = 20'sh7ffff; w.center_z = 20'sh80000;
        w.first_x = 20'sh7ffff; w.second_y = 20'sh80000; w.third_z = 20'sh7ffff;
        send_word(w);
        w = {12{20'sh7ffff}};
        send_word(w);
        w = {12{20'sh80000}};
        send_word(w);
        drain();
        set_box(19'h7ffff, 19'h7ffff, 19'h7ffff);
        send_word(w);
        w.first_x = 20'sh7ffff; w.second_y = 20'sh7ffff; w.third_z = 20'sh7ffff;
        send_word(w);
        w = '1;
        send_word(w);
        send_word(tri_at(0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_random_phase(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                send_word(make_triangle(3000, 1200));
            else if (r < 8)
                send_word(make_triangle(1, 60000));
            else if (r < 9)
                send_word(make_triangle(0, 1));
            else
                send_word(make_triangle(1, 1));
        end
        drain();
    endtask

    task automatic test_box_settings;
        set_box(19'd0, 19'd0, 19'd0);
        test_random_phase(60);
        set_box(19'd500, 19'd900, 19'd300);
        test_random_phase(80);
        set_box(HALF_WIDTH'($urandom), HALF_WIDTH'($urandom), HALF_WIDTH'($urandom));
        test_random_phase(80);
        set_box(19'h7ffff, 19'd0, 19'd1000);
        test_random_phase(60);
        set_box(19'd1200, 19'd1200, 19'd1200);
        test_random_phase(80);
    endtask

    task automatic test_backpressure;
        hold_cycles = 200;
        hold_off = 1'b1;
        for (int n = 0; n < 30; n++)
            send_word(make_triangle(3000, 1200));
        drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_off)
        begin
            result.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles <= 1)
                hold_off <= 1'b0;
        end
        else if (result.valid && result.ready)
        begin
            rx_draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            rx_wait <= rx_draw;
            result.ready <= (rx_draw == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            result.ready <= (rx_wait == 1);
        end
        else
            result.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_flags.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("overlap flag %0b with nothing expected", result.data.overlaps);
            end
            else if (result.data.overlaps !== expected_flags[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("overlap flag mismatch: expected %0b, actual %0b",
                             expected_flags[0], result.data.overlaps);
                void'(expected_flags.pop_front());
            end
            else
                void'(expected_flags.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        item.valid = 1'b0;
        item.data = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        result.ready = 1'b0;
        for (int k = 0; k < 3; k++)
            box_half[k] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_box_settings();
        test_backpressure();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_flags.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> filelist.f
sv/tbo_pkg.sv
sv/tbo_item_if.sv
sv/tbo_result_if.sv
sv/tbo_cfg_if.sv
sv/triangle_box_overlap_test.sv
dv/tb_triangle_box_overlap_test.sv
